// File: design/window_filter_3x3_blur_sharpen_defines.svh
// Assertion macros for the window filter checker.
`ifndef WINDOW_FILTER_3X3_BLUR_SHARPEN_DEFINES_SVH
`define WINDOW_FILTER_3X3_BLUR_SHARPEN_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define WF3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define WF3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/wf3_pkg.sv
// Types, constants and codes shared by the 3x3 window filter.
package wf3_pkg;

	localparam int DEF_WIDTH  = 64;
	localparam int DEF_HEIGHT = 64;

	localparam int PIX_CW   = 8;
	localparam int CHANNELS = 3;
	localparam int PIX_W    = PIX_CW * CHANNELS;
	localparam int LINE_W   = 2 * PIX_W;   // {row two up, row one up}

	localparam int WIN_N = 3;
	localparam int TAPS  = WIN_N * WIN_N;
	localparam int TAP_N = 1;
	localparam int TAP_W = 3;
	localparam int TAP_C = 4;
	localparam int TAP_E = 5;
	localparam int TAP_S = 7;

	// box sum of nine bytes, sharpen value as signed
	localparam int SUM_W   = 12;
	localparam int SHARP_W = 12;

	// floor(x/9) = (x*1821) >> 14 for x below 2296
	localparam int DIV9_MUL   = 1821;
	localparam int DIV9_MUL_W = 11;
	localparam int DIV9_SHIFT = 14;
	localparam int PROD_W     = SUM_W + DIV9_MUL_W;

	localparam int PIX_MAX = 255;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_FILTER_MODE = 1'b0;   // word index, paddr[2]

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic {
		MODE_BLUR  = 1'b0,
		MODE_SHARP = 1'b1
	} mode_t;

	typedef struct packed {
		logic [PIX_CW-1:0] in_red;
		logic [PIX_CW-1:0] in_green;
		logic [PIX_CW-1:0] in_blue;
		logic              flush;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_CW-1:0] out_red;
		logic [PIX_CW-1:0] out_green;
		logic [PIX_CW-1:0] out_blue;
		logic              end_of_frame;
	} pix_out_t;

	typedef struct packed {
		logic  load;     // s1 -> s2 move of an emitting word
		mode_t mode;
		logic  border;   // s2: pass the center through
		logic  flush;    // s2: pass the raw line value through
	} lane_ctl_t;

endpackage

// File: design/wf3_line_buf.sv
// Two packed line rows in one RAM, one write and one registered read port.
module wf3_line_buf #(
	parameter int DEPTH = wf3_pkg::DEF_WIDTH
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [wf3_pkg::LINE_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [wf3_pkg::LINE_W-1:0] rd_data
);
	import wf3_pkg::*;

	logic [LINE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/wf3_lane.sv
// One color channel of the filter: window sums, then divide/clamp and select.
module wf3_lane (
	input  logic                                    clk,
	input  wf3_pkg::lane_ctl_t                      ctl,
	input  logic [wf3_pkg::TAPS-1:0][wf3_pkg::PIX_CW-1:0] taps,
	input  logic [wf3_pkg::PIX_CW-1:0]              raw,
	output logic [wf3_pkg::PIX_CW-1:0]              result
);
	import wf3_pkg::*;

	logic        [SUM_W-1:0]   box_sum;
	logic        [SUM_W-1:0]   box_sum_s2;
	logic signed [SHARP_W-1:0] sharp;
	logic signed [SHARP_W-1:0] sharp_s2;
	logic        [PIX_CW-1:0]  center_s2;
	logic        [PROD_W-1:0]  prod;
	logic        [PIX_CW-1:0]  blur_px;
	logic        [PIX_CW-1:0]  sharp_px;

	always_comb begin
		box_sum = '0;
		for (int i = 0; i < TAPS; i++) begin
			box_sum = box_sum + SUM_W'(taps[i]);
		end
	end

	// 5*c - n - s - w - e, wraps cleanly into two's complement
	assign sharp = SHARP_W'({taps[TAP_C], 2'b00}) + SHARP_W'(taps[TAP_C])
		- SHARP_W'(taps[TAP_N]) - SHARP_W'(taps[TAP_S])
		- SHARP_W'(taps[TAP_W]) - SHARP_W'(taps[TAP_E]);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			box_sum_s2 <= box_sum;
			sharp_s2   <= sharp;
			center_s2  <= taps[TAP_C];
		end
	end

	assign prod    = PROD_W'(box_sum_s2) * PROD_W'(DIV9_MUL);
	assign blur_px = prod[DIV9_SHIFT +: PIX_CW];

	always_comb begin
		priority if (sharp_s2 < 0) begin
			sharp_px = '0;
		end else if (sharp_s2 > SHARP_W'(PIX_MAX)) begin
			sharp_px = PIX_CW'(PIX_MAX);
		end else begin
			sharp_px = sharp_s2[PIX_CW-1:0];
		end
	end

	always_comb begin
		priority if (ctl.flush) begin
			result = raw;
		end else if (ctl.border) begin
			result = center_s2;
		end else begin
			unique case (ctl.mode)
				MODE_BLUR:  result = blur_px;
				MODE_SHARP: result = sharp_px;
				default:    result = blur_px;
			endcase
		end
	end

endmodule

// File: design/window_filter_3x3_blur_sharpen.sv
// Top level of the 3x3 box blur / sharpen window filter for RGB raster streams.
//
// Pixel channel: pix_valid / pix_stall / pix_word. A word is taken at a clock edge
// with pix_valid high and pix_stall low. A word with flush set carries no pixel and
// pushes out the oldest pending pixel raw from the line rows (none if none pend).
// Result channel: res_valid / res_stall / res_word, same rules, receiver stalls.
// A pixel word makes a result once WIDTH+1 earlier pixels are pending: the pixel
// WIDTH+1 places back, filtered, or unchanged on the frame border.
// Throughput: one word per cycle while the result channel does not stall, set by
// the one-read one-write line RAM; three channel lanes work side by side and merge
// into the output register. A stalled result sits in the output register while
// the two stages behind it keep taking words; pix_stall rises only once every
// stage holds a word. Reset (arst_n low) clears counters, window, stage valids and
// filter_mode (box blur); the line RAM is not cleared and needs no clearing pass.
// filter_mode is an APB register at byte address 0; the user is to write it only
// while idle, and the block itself does not enforce this.
module window_filter_3x3_blur_sharpen #(
	parameter int WIDTH  = wf3_pkg::DEF_WIDTH,
	parameter int HEIGHT = wf3_pkg::DEF_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  wf3_pkg::pix_in_t            pix_word,
	output logic                        res_valid,
	input  logic                        res_stall,
	output wf3_pkg::pix_out_t           res_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wf3_pkg::APB_AW-1:0]  paddr,
	input  logic [wf3_pkg::APB_DW-1:0]  pwdata,
	output logic [wf3_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import wf3_pkg::*;

	localparam int CW = $clog2(WIDTH);
	localparam int RW = $clog2(HEIGHT);
	localparam int PW = $clog2(WIDTH + 2);

	// ---- config register ----
	mode_t mode_q;

	// ---- position counters ----
	logic [CW-1:0] col_q;    // next incoming pixel
	logic [RW-1:0] row_q;
	logic [CW-1:0] tcol_q;   // oldest pending pixel
	logic [RW-1:0] trow_q;
	logic [PW-1:0] pend_q;   // pixels in, not yet out

	// ---- stage 1: line RAM data back, window shift ----
	logic          v_s1;
	logic          flush_s1;
	logic          emit_s1;
	logic          border_s1;
	logic          eof_s1;
	logic          sel1_s1;
	logic [CW-1:0] col_s1;
	pixel_t        px_s1;
	logic          hit_s1;
	logic [LINE_W-1:0] byp_s1;
	logic [LINE_W-1:0] rd_s1;

	// ---- stage 2: lane sums ----
	logic   v_s2;
	logic   flush_s2;
	logic   border_s2;
	logic   eof_s2;
	pixel_t raw_s2;

	// ---- output register ----
	logic     res_valid_q;
	pix_out_t res_q;

	pixel_t win_q   [WIN_N][WIN_N];
	pixel_t new_win [WIN_N][WIN_N];

	logic accept, is_flush, pend_zero, pend_full, emit0, go_s1;
	logic tail_border, tail_last, col_last, row_last, tcol_last, trow_last;
	logic out_free, s2_free, s1_move, s2_load, s2_move;
	logic [CW-1:0] rd_addr;
	logic [LINE_W-1:0] rd_eff;
	logic [LINE_W-1:0] wr_data;
	logic wr_en;
	logic cfg_wr;

	logic [CHANNELS-1:0][TAPS-1:0][PIX_CW-1:0] lane_taps;
	logic [CHANNELS-1:0][PIX_CW-1:0]           lane_res;
	lane_ctl_t lane_ctl;

	// ---- config port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILTER_MODE);
	assign prdata = (paddr[2] == REG_FILTER_MODE) ? APB_DW'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BLUR;
		end else if (cfg_wr) begin
			mode_q <= mode_t'(pwdata[0]);
		end
	end

	// ---- handshake and stage flow ----
	assign out_free  = !res_valid_q || !res_stall;
	assign s2_free   = !v_s2 || out_free;
	assign s1_move   = v_s1 && (!emit_s1 || s2_free);
	assign pix_stall = v_s1 && !s1_move;
	assign accept    = pix_valid && !pix_stall;
	assign s2_load   = s1_move && emit_s1;
	assign s2_move   = v_s2 && out_free;

	// ---- entry decode ----
	assign is_flush  = pix_word.flush;
	assign pend_zero = (pend_q == '0);
	assign pend_full = (pend_q == PW'(WIDTH + 1));
	assign emit0     = is_flush ? !pend_zero : pend_full;
	// a flush with nothing pending is taken and dropped
	assign go_s1     = accept && !(is_flush && pend_zero);

	assign col_last    = (col_q == CW'(WIDTH - 1));
	assign row_last    = (row_q == RW'(HEIGHT - 1));
	assign tcol_last   = (tcol_q == CW'(WIDTH - 1));
	assign trow_last   = (trow_q == RW'(HEIGHT - 1));
	assign tail_border = (trow_q == '0) || trow_last || (tcol_q == '0) || tcol_last;
	assign tail_last   = tcol_last && trow_last;
	assign rd_addr     = is_flush ? tcol_q : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			tcol_q <= '0;
			trow_q <= '0;
			pend_q <= '0;
		end else if (go_s1) begin
			if (!is_flush) begin
				col_q <= col_last ? '0 : col_q + CW'(1);
				if (col_last) begin
					row_q <= row_last ? '0 : row_q + RW'(1);
				end
			end
			// a full backlog stays full: one in, one out
			if (is_flush) begin
				pend_q <= pend_q - PW'(1);
			end else if (!pend_full) begin
				pend_q <= pend_q + PW'(1);
			end
			if (emit0) begin
				tcol_q <= tcol_last ? '0 : tcol_q + CW'(1);
				if (tcol_last) begin
					trow_q <= trow_last ? '0 : trow_q + RW'(1);
				end
			end
		end
	end

	// ---- stage 1 ----
	// forward the row being written by the word leaving s1 into the word entering
	assign rd_eff  = hit_s1 ? byp_s1 : rd_s1;
	assign wr_en   = s1_move && !flush_s1;
	assign wr_data = {rd_eff[PIX_W-1:0], px_s1};

	wf3_line_buf #(
		.DEPTH(WIDTH)
	) u_line_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(col_s1),
		.wr_data(wr_data),
		.rd_en  (go_s1),
		.rd_addr(rd_addr),
		.rd_data(rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go_s1) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			flush_s1  <= is_flush;
			emit_s1   <= emit0;
			border_s1 <= tail_border;
			eof_s1    <= tail_last;
			sel1_s1   <= (pend_q > PW'(WIDTH));
			col_s1    <= col_q;
			px_s1     <= {pix_word.in_blue, pix_word.in_green, pix_word.in_red};
			hit_s1    <= wr_en && (col_s1 == rd_addr);
			byp_s1    <= wr_data;
		end
	end

	// window after this pixel: shift left, new right column from RAM and input
	always_comb begin
		for (int r = 0; r < WIN_N; r++) begin
			new_win[r][0] = win_q[r][1];
			new_win[r][1] = win_q[r][2];
		end
		new_win[0][2] = rd_eff[LINE_W-1:PIX_W];
		new_win[1][2] = rd_eff[PIX_W-1:0];
		new_win[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN_N; r++) begin
				for (int k = 0; k < WIN_N; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else if (wr_en) begin
			win_q <= new_win;
		end
	end

	// ---- lanes: one per color channel ----
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int r = 0; r < WIN_N; r++) begin
				for (int k = 0; k < WIN_N; k++) begin
					lane_taps[ch][r*WIN_N + k] = new_win[r][k][ch*PIX_CW +: PIX_CW];
				end
			end
		end
	end

	assign lane_ctl = '{load: s2_load, mode: mode_q, border: border_s2, flush: flush_s2};

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		wf3_lane u_lane (
			.clk   (clk),
			.ctl   (lane_ctl),
			.taps  (lane_taps[ch]),
			.raw   (raw_s2[ch*PIX_CW +: PIX_CW]),
			.result(lane_res[ch])
		);
	end

	// ---- stage 2 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_load) begin
			v_s2 <= 1'b1;
		end else if (s2_move) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			flush_s2  <= flush_s1;
			border_s2 <= border_s1;
			eof_s2    <= eof_s1;
			raw_s2    <= sel1_s1 ? rd_eff[LINE_W-1:PIX_W] : rd_eff[PIX_W-1:0];
		end
	end

	// ---- merge into the output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_move) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			res_q.out_red      <= lane_res[0];
			res_q.out_green    <= lane_res[1];
			res_q.out_blue     <= lane_res[2];
			res_q.end_of_frame <= eof_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

// File: design/wf3_checker.sv
// Port-level checker for the window filter, bound to the top level.
`include "window_filter_3x3_blur_sharpen_defines.svh"

module wf3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pix_valid,
	input logic                        pix_stall,
	input wf3_pkg::pix_in_t            pix_word,
	input logic                        res_valid,
	input logic                        res_stall,
	input wf3_pkg::pix_out_t           res_word,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [wf3_pkg::APB_AW-1:0]  paddr,
	input logic [wf3_pkg::APB_DW-1:0]  pwdata,
	input logic [wf3_pkg::APB_DW-1:0]  prdata,
	input logic                        pready
);

	// input backs up only when every stage, output included, is full and stalled
	`WF3_ASSERT_NOW(a_stall_needs_full, clk, arst_n, pix_stall, res_valid && res_stall, "input stalled with room in the pipe")

	// a stalled result holds
	`WF3_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_word), "stalled result changed")

	// mode readback follows the last write
	`WF3_ASSERT_NEXT(a_mode_readback, clk, arst_n, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[0] == $past(pwdata[0])), "filter_mode readback wrong")

	`WF3_ASSERT_NOW(a_pready_high, clk, arst_n, psel && penable, pready, "pready low in access")

endmodule

bind window_filter_3x3_blur_sharpen wf3_checker u_wf3_checker (.*);

// File: tb/sv/tb_window_filter_3x3_blur_sharpen.sv
// Self-checking testbench for the 3x3 box blur / sharpen window filter.
`timescale 1ns / 100ps

module tb_window_filter_3x3_blur_sharpen;
	import wf3_pkg::*;

	localparam int W           = DEF_WIDTH;
	localparam int H           = DEF_HEIGHT;
	localparam int FRAME_PX    = W * H;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_ERRORS = 40;

	// ---------------------------------------------------------------
	// Clock, reset and block inputs, all known from time zero
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_in_t pix_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	pix_out_t res_word;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	window_filter_3x3_blur_sharpen #(
		.WIDTH(W),
		.HEIGHT(H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_word(pix_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// ---------------------------------------------------------------
	// Shared test state
	// ---------------------------------------------------------------
	int error_count = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;    // chance per cycle that the sender holds off
	int rcv_stall_pct = 0;   // chance per cycle that the receiver stalls

	// Expected result words, oldest first
	pix_out_t due_pixels[$];

	// Shadow of the filter: two line rows, the 3x3 window, position and backlog.
	// row_above holds the row just above the incoming pixel, row_two_up the one
	// above that. Packing per pixel: red in [7:0], green [15:8], blue [23:16].
	pixel_t row_above[W];
	pixel_t row_two_up[W];
	pixel_t win[3][3];
	int col_pos = 0;
	int row_pos = 0;
	int backlog = 0;          // pixels taken but not yet sent out
	mode_t cur_mode = MODE_BLUR;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= SHOW_ERRORS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	// Raster index of the oldest pixel still in the backlog
	function automatic int oldest_pos();
		return (row_pos * W + col_pos + FRAME_PX - backlog) % FRAME_PX;
	endfunction

	// Box blur or four-neighbour sharpen of the window center, per channel
	function automatic pixel_t window_filtered();
		pixel_t res;
		int sum;
		int s;
		res = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (cur_mode == MODE_BLUR) begin
				sum = 0;
				for (int r = 0; r < 3; r++)
					for (int k = 0; k < 3; k++)
						sum += win[r][k][8*c +: 8];
				res[8*c +: 8] = 8'(sum / 9);
			end else begin
				s = 5 * int'(win[1][1][8*c +: 8]) - int'(win[0][1][8*c +: 8])
				  - int'(win[2][1][8*c +: 8]) - int'(win[1][0][8*c +: 8])
				  - int'(win[1][2][8*c +: 8]);
				if (s < 0) s = 0;
				if (s > PIX_MAX) s = PIX_MAX;
				res[8*c +: 8] = 8'(s);
			end
		end
		return res;
	endfunction

	function automatic pix_out_t out_word(input pixel_t px, input int idx);
		pix_out_t o;
		o.out_red      = px[7:0];
		o.out_green    = px[15:8];
		o.out_blue     = px[23:16];
		o.end_of_frame = (idx == FRAME_PX - 1);
		return o;
	endfunction

	// Advance the shadow by one accepted word; queue the result it causes
	task automatic predict_filter(input pix_in_t w);
		pixel_t px;
		int idx;
		int orow;
		int ocol;
		if (w.flush) begin
			// flush pushes the oldest pending pixel out raw, nothing if none
			if (backlog == 0)
				return;
			idx = oldest_pos();
			ocol = idx % W;
			px = (backlog > W) ? row_two_up[ocol] : row_above[ocol];
			due_pixels.push_back(out_word(px, idx));
			backlog--;
			return;
		end
		px = {w.in_blue, w.in_green, w.in_red};
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = row_two_up[col_pos];
		win[1][2] = row_above[col_pos];
		win[2][2] = px;
		row_two_up[col_pos] = row_above[col_pos];
		row_above[col_pos] = px;
		col_pos++;
		if (col_pos >= W) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= H)
				row_pos = 0;
		end
		backlog++;
		if (backlog < W + 2)
			return;
		idx = oldest_pos();
		orow = idx / W;
		ocol = idx % W;
		// frame border passes the center through unchanged
		if (orow == 0 || orow == H - 1 || ocol == 0 || ocol == W - 1)
			px = win[1][1];
		else
			px = window_filtered();
		due_pixels.push_back(out_word(px, idx));
		backlog--;
	endtask

	// ---------------------------------------------------------------
	// Result side: random stall, compare every accepted word
	// ---------------------------------------------------------------
	task automatic check_result(input pix_out_t got);
		pix_out_t want;
		if (due_pixels.size() == 0) begin
			report_mismatch($sformatf("result %h with none expected", got));
			return;
		end
		want = due_pixels.pop_front();
		if (got.out_red !== want.out_red)
			report_mismatch($sformatf("out_red %h, want %h", got.out_red, want.out_red));
		if (got.out_green !== want.out_green)
			report_mismatch($sformatf("out_green %h, want %h",
				got.out_green, want.out_green));
		if (got.out_blue !== want.out_blue)
			report_mismatch($sformatf("out_blue %h, want %h",
				got.out_blue, want.out_blue));
		if (got.end_of_frame !== want.end_of_frame)
			report_mismatch($sformatf("end_of_frame %b, want %b",
				got.end_of_frame, want.end_of_frame));
	endtask

	// Values read here are the ones from before this edge; res_stall is
	// read before its new value is scheduled.
	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && !res_stall)
			check_result(res_word);
		res_stall <= arst_n && ($urandom_range(99) < rcv_stall_pct);
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sender and register access
	// ---------------------------------------------------------------
	// Present one word, hold it until taken, then update the shadow
	task automatic send_word(input pix_in_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_word <= w;
		do @(posedge clk); while (pix_stall !== 1'b0);
		predict_filter(w);
	endtask

	// Stop sending and let every expected word come out
	task automatic drain();
		pix_valid <= 1'b0;
		while (due_pixels.size() != 0)
			@(posedge clk);
		// flushes with nothing pending may still be in the pipe
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data,
			output logic [APB_DW-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_FILTER_MODE, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Write filter_mode with junk in the unused bits, then read it back
	task automatic set_filter_mode(input mode_t m);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, {31'($urandom()), m}, rd);
		cur_mode = m;
		@(posedge clk);
		apb_access(1'b0, '0, rd);
		if (rd !== APB_DW'(m))
			report_mismatch($sformatf("filter_mode read %h, want %h", rd, m));
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic pix_in_t rand_pixel();
		return '{in_red: rand_chan(), in_green: rand_chan(), in_blue: rand_chan(),
			flush: 1'b0};
	endfunction

	// colour bits of a flush are don't-care, so toggle them freely
	function automatic pix_in_t flush_word();
		return '{in_red: 8'($urandom()), in_green: 8'($urandom()),
			in_blue: 8'($urandom()), flush: 1'b1};
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Flush words straight after reset: nothing pending, no result
	task automatic test_flush_when_empty();
		set_filter_mode(MODE_SHARP);
		repeat (3) send_word(flush_word());
		drain();
	endtask

	// Extreme and patterned pixels, then flushes that push out raw pixels
	task automatic test_extreme_pixels();
		logic [23:0] pat[20] = '{
			24'h000000, 24'hFFFFFF, 24'hAA55AA, 24'h55AA55, 24'hFF0000,
			24'h00FF00, 24'h0000FF, 24'h808080, 24'h7F7F7F, 24'h010101,
			24'hFEFEFE, 24'hFFFFFF, 24'h000000, 24'hF0F00F, 24'h0F0FF0,
			24'hFFFFFF, 24'h000000, 24'h123456, 24'hFEDCBA, 24'h800000};
		foreach (pat[i])
			send_word('{in_red: pat[i][23:16], in_green: pat[i][15:8],
				in_blue: pat[i][7:0], flush: 1'b0});
		repeat (2) send_word(flush_word());
		drain();
	endtask

	// Raster stream with random content; rare flushes and flush bursts
	// break it up. Consecutive calls continue the same stream.
	task automatic test_stream(input mode_t m, input int gap_pct, input int stall_pct,
			input int n_words);
		int burst;
		set_filter_mode(m);
		send_gap_pct = gap_pct;
		rcv_stall_pct = stall_pct;
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(99) == 0) begin
				burst = $urandom_range(70, 1);
				repeat (burst) send_word(flush_word());
			end else if ($urandom_range(99) < 4) begin
				send_word(flush_word());
			end else begin
				send_word(rand_pixel());
			end
		end
		drain();
	endtask

	// Finish the current row, then flush out the whole pending tail
	task automatic test_frame_tail(input mode_t m);
		set_filter_mode(m);
		send_gap_pct = 14;
		rcv_stall_pct = 14;
		do send_word(rand_pixel()); while (col_pos != 0);
		while (backlog > 0)
			send_word(flush_word());
		// one more with the backlog empty
		send_word(flush_word());
		drain();
	endtask

	// ---------------------------------------------------------------
	// Run
	// ---------------------------------------------------------------
	initial begin
		int waited;
		foreach (row_above[i]) begin
			row_above[i] = '0;
			row_two_up[i] = '0;
		end
		foreach (win[r, k])
			win[r][k] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flush_when_empty();
		test_extreme_pixels();
		// four idle profiles, the stream carried on from one to the next
		test_stream(MODE_BLUR, 0, 0, 85);
		test_stream(MODE_SHARP, 69, 0, 85);
		test_stream(MODE_BLUR, 0, 69, 85);
		test_stream(MODE_SHARP, 14, 14, 85);
		test_frame_tail(MODE_BLUR);

		// final wait, bounded
		pix_valid <= 1'b0;
		waited = 0;
		while (due_pixels.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
		if (due_pixels.size() != 0)
			report_mismatch($sformatf("%0d expected words never came", due_pixels.size()));

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
